>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> src/mfrr_pkg.sv
// ----------------------------------------------------------------------------
// mfrr_pkg
// Types and constants shared by the round-robin ring FIFO merge.
// ----------------------------------------------------------------------------
`default_nettype none

package mfrr_pkg;

  // Fixed field widths of the item and result ports
  localparam int OUT_EVENT_W = 32;
  localparam int QIDX_W      = 2;
  localparam int STATUS_W    = 2;

  // Operation codes
  localparam logic OP_SEND = 1'b0;
  localparam logic OP_RECV = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_DROP   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_REFUSE = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd3;

  // Register indexes (paddr[2])
  localparam logic REG_ACTIVE = 1'b0;
  localparam logic REG_RING   = 1'b1;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEND,
    ST_PICK,
    ST_DATA
  } mfrr_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;      // latch the accepted beat
    logic send_commit;  // ring update, memory write, result load
    logic rx_reduce;    // pull scan start back into range
    logic rx_pick;      // scan, pop pointer update, memory read
    logic rx_finish;    // load receive result
  } mfrr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_recv;      // incoming beat is a receive
    logic start_wrap;   // scan start not below active count
    logic out_free;     // result register can take a new result
  } mfrr_sts_t;

endpackage

`default_nettype wire

>>> src/mfrr_ctrl.sv
// ----------------------------------------------------------------------------
// mfrr_ctrl
// Item sequencer: accepts one beat, steps send or receive, hands off result.
// ----------------------------------------------------------------------------
`default_nettype none

module mfrr_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire mfrr_pkg::mfrr_sts_t sts,
  output mfrr_pkg::mfrr_cmd_t  cmd
);
  import mfrr_pkg::*;

  mfrr_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = sts.in_recv ? ST_PICK : ST_SEND;
      end
      ST_SEND: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      ST_PICK: begin
        if (!sts.start_wrap) state_nxt = ST_DATA;
      end
      ST_DATA: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_SEND: cmd.send_commit = sts.out_free;
      ST_PICK: begin
        cmd.rx_reduce = sts.start_wrap;
        cmd.rx_pick   = !sts.start_wrap;
      end
      ST_DATA: cmd.rx_finish = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> src/mfrr_dpath.sv
// ----------------------------------------------------------------------------
// mfrr_dpath
// Ring pointers, event memory, round-robin pick and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mfrr_dpath #(
  parameter int NUM_QUEUES  = 4,
  parameter int QUEUE_DEPTH = 16,
  parameter int EVENT_WIDTH = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire mfrr_pkg::mfrr_cmd_t             cmd,
  output mfrr_pkg::mfrr_sts_t                  sts,
  input  wire logic                            in_operation,
  input  wire logic [mfrr_pkg::QIDX_W-1:0]     in_queue_index,
  input  wire logic [mfrr_pkg::OUT_EVENT_W-1:0] in_event_data,
  input  wire logic                            in_allow_drop,
  input  wire logic [2:0]                      active_queues,
  input  wire logic [4:0]                      ring_size,
  input  wire logic                            ring_clr,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [mfrr_pkg::OUT_EVENT_W-1:0]     out_event,
  output logic [mfrr_pkg::QIDX_W-1:0]          out_source_queue,
  output logic [mfrr_pkg::STATUS_W-1:0]        out_status
);
  import mfrr_pkg::*;

  localparam int QIW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int IW  = $clog2(QUEUE_DEPTH);
  localparam int NAW = $clog2(NUM_QUEUES + 1);
  localparam int MD  = NUM_QUEUES * QUEUE_DEPTH;
  localparam int AW  = $clog2(MD);
  localparam int SW  = (EVENT_WIDTH < OUT_EVENT_W) ? EVENT_WIDTH : OUT_EVENT_W;

  // Ring pointers and round-robin history
  logic [IW-1:0]  wr_idx_r [NUM_QUEUES];
  logic [IW-1:0]  rd_idx_r [NUM_QUEUES];
  logic [QIW-1:0] ls_r;

  // Captured beat
  logic [QIW-1:0] q_r;
  logic [SW-1:0]  data_r;
  logic           drop_r;
  logic [NAW-1:0] start_r;

  // Receive bookkeeping and memory
  logic           found_r;
  logic [QIW-1:0] src_r;
  logic [SW-1:0]  rd_data_r;
  logic [SW-1:0]  mem [MD];

  // Result register
  logic                   out_valid_r;
  logic [OUT_EVENT_W-1:0] out_event_r;
  logic [QIDX_W-1:0]      out_src_r;
  logic [STATUS_W-1:0]    out_status_r;

  logic [NAW-1:0]        na;
  logic [IW-1:0]         ring_last;
  logic [QIW-1:0]        q_in;
  logic [IW-1:0]         wr_nxt [NUM_QUEUES];
  logic [IW-1:0]         rd_nxt [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] full;
  logic [NUM_QUEUES-1:0] nonempty;
  logic                  hit_hi, hit_lo, hit;
  logic [QIW-1:0]        pick_hi, pick_lo, pick_q;
  logic                  out_free;
  logic                  mem_we;
  logic [AW-1:0]         waddr, raddr;

  // Effective active count and last ring slot, clamped to the legal range
  always_comb begin
    int act_i;
    int rs_i;
    act_i = int'(active_queues);
    if (act_i < 1) act_i = 1;
    else if (act_i > NUM_QUEUES) act_i = NUM_QUEUES;
    na = NAW'(act_i);
    rs_i = int'(ring_size);
    if (rs_i < 2) rs_i = 2;
    else if (rs_i > QUEUE_DEPTH) rs_i = QUEUE_DEPTH;
    ring_last = IW'(rs_i - 1);
  end

  // Queue index modulo the queue count; one subtraction covers two index bits
  assign q_in = (int'(in_queue_index) >= NUM_QUEUES) ?
                QIW'(int'(in_queue_index) - NUM_QUEUES) : QIW'(in_queue_index);

  // Per-ring next pointers, full and non-empty flags
  always_comb begin
    for (int q = 0; q < NUM_QUEUES; q++) begin
      wr_nxt[q]   = (wr_idx_r[q] == ring_last) ? '0 : wr_idx_r[q] + IW'(1);
      rd_nxt[q]   = (rd_idx_r[q] == ring_last) ? '0 : rd_idx_r[q] + IW'(1);
      full[q]     = (wr_nxt[q] == rd_idx_r[q]);
      nonempty[q] = (q < int'(na)) && (rd_idx_r[q] != wr_idx_r[q]);
    end
  end

  // Round-robin pick: lowest ring at or after start, else lowest overall
  always_comb begin
    hit_hi  = 1'b0;
    hit_lo  = 1'b0;
    pick_hi = '0;
    pick_lo = '0;
    for (int q = NUM_QUEUES - 1; q >= 0; q--) begin
      if (nonempty[q] && (q >= int'(start_r))) begin
        hit_hi  = 1'b1;
        pick_hi = QIW'(q);
      end
      if (nonempty[q]) begin
        hit_lo  = 1'b1;
        pick_lo = QIW'(q);
      end
    end
    hit    = hit_hi | hit_lo;
    pick_q = hit_hi ? pick_hi : pick_lo;
  end

  assign out_free = !out_valid_r || !out_stall;
  assign mem_we   = cmd.send_commit && !full[q_r];
  assign waddr    = AW'(QUEUE_DEPTH) * AW'(q_r) + AW'(wr_idx_r[q_r]);
  assign raddr    = AW'(QUEUE_DEPTH) * AW'(pick_q) + AW'(rd_idx_r[pick_q]);

  assign sts.in_recv    = (in_operation == OP_RECV);
  assign sts.start_wrap = (start_r >= na);
  assign sts.out_free   = out_free;

  // Pointer and history registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
        wr_idx_r[q] <= '0;
        rd_idx_r[q] <= '0;
      end
      ls_r <= '0;
    end else if (ring_clr) begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
        wr_idx_r[q] <= '0;
        rd_idx_r[q] <= '0;
      end
    end else begin
      if (mem_we) wr_idx_r[q_r] <= wr_nxt[q_r];
      if (cmd.rx_pick && hit) begin
        rd_idx_r[pick_q] <= rd_nxt[pick_q];
        ls_r             <= pick_q;
      end
    end
  end

  // Beat capture and scan start
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      q_r     <= q_in;
      data_r  <= in_event_data[SW-1:0];
      drop_r  <= in_allow_drop;
      start_r <= NAW'(ls_r) + NAW'(1);
    end else if (cmd.rx_reduce) begin
      start_r <= start_r - na;
    end
    if (cmd.rx_pick) begin
      found_r <= hit;
      src_r   <= pick_q;
    end
  end

  // Event memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= data_r;
    if (cmd.rx_pick && hit) rd_data_r <= mem[raddr];
  end

  // Result register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.send_commit || cmd.rx_finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.send_commit) begin
      out_event_r <= '0;
      out_src_r   <= '0;
      if (!full[q_r]) out_status_r <= STAT_OK;
      else out_status_r <= drop_r ? STAT_DROP : STAT_REFUSE;
    end else if (cmd.rx_finish) begin
      out_event_r  <= found_r ? OUT_EVENT_W'(rd_data_r) : '0;
      out_src_r    <= found_r ? QIDX_W'(src_r) : '0;
      out_status_r <= found_r ? STAT_OK : STAT_EMPTY;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event        = out_event_r;
  assign out_source_queue = out_src_r;
  assign out_status       = out_status_r;

endmodule

`default_nettype wire

>>> src/multi_fifo_round_robin_merge.sv
// ----------------------------------------------------------------------------
// multi_fifo_round_robin_merge
// Ring FIFOs of events merged by a round-robin reader, with APB setup regs.
// ----------------------------------------------------------------------------
// One beat is worked at a time. A send holds the input through the accept
// step and a ring update and memory write step, after which its result is
// valid. A receive holds it through accept, scan with memory read and data
// return, plus a reduce step before the scan for each subtraction of the
// active count that brings the scan start (one past the queue served last)
// below the active count: one when the highest active queue was served
// last, up to NUM_QUEUES when active_queues was lowered to 1 after the top
// queue was served. A result held in the output register by out_stall
// delays only the final step. Ring pointers are flip-flops cleared at reset
// and on any ring_size write; the event memory is never cleared. Registers:
// 0x0 active_queues (3 bits), 0x4 ring_size (5 bits); paddr[1:0] is ignored.
`default_nettype none
`include "assert_macros.svh"

module multi_fifo_round_robin_merge #(
  parameter int NUM_QUEUES  = 4,
  parameter int QUEUE_DEPTH = 16,
  parameter int EVENT_WIDTH = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Item channel
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             in_operation,
  input  wire logic [mfrr_pkg::QIDX_W-1:0]      in_queue_index,
  input  wire logic [mfrr_pkg::OUT_EVENT_W-1:0] in_event_data,
  input  wire logic                             in_allow_drop,
  // Result channel
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [mfrr_pkg::OUT_EVENT_W-1:0]      out_event,
  output logic [mfrr_pkg::QIDX_W-1:0]           out_source_queue,
  output logic [mfrr_pkg::STATUS_W-1:0]         out_status,
  // Configuration
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [2:0]                       paddr,
  input  wire logic [31:0]                      pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);
  import mfrr_pkg::*;

  logic [2:0] act_r;
  logic [4:0] ring_r;
  logic       cfg_wr;
  logic       ring_clr;
  mfrr_cmd_t  cmd;
  mfrr_sts_t  sts;

  // APB register file
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign ring_clr = cfg_wr && (paddr[2] == REG_RING);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 3'd4;
      ring_r <= 5'd16;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_ACTIVE) act_r <= pwdata[2:0];
      else ring_r <= pwdata[4:0];
    end
  end

  assign prdata = (paddr[2] == REG_RING) ? 32'(ring_r) : 32'(act_r);

  mfrr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mfrr_dpath #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .EVENT_WIDTH (EVENT_WIDTH)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_operation     (in_operation),
    .in_queue_index   (in_queue_index),
    .in_event_data    (in_event_data),
    .in_allow_drop    (in_allow_drop),
    .active_queues    (act_r),
    .ring_size        (ring_r),
    .ring_clr         (ring_clr),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event        (out_event),
    .out_source_queue (out_source_queue),
    .out_status       (out_status)
  );

  // One beat in flight: an accepted beat stalls the input next cycle
  `ASSERT_CLK(a_one_in_flight, (in_valid && !in_stall) |=> in_stall, "second beat taken early")
  // Only a successful receive carries event data
  `ASSERT_CLK(a_zero_on_fail, (out_valid && out_status != STAT_OK) |-> out_event == '0, "fail data")
  // A new result appears only while a beat is being worked
  `ASSERT_CLK(a_no_phantom, $rose(out_valid) |-> $past(in_stall), "result without a beat")
  // Reset empties the result register
  `ASSERT_CLK_ALWAYS(a_rst_out, !rst_n |=> !out_valid, "result valid after reset")

endmodule

`default_nettype wire
